// File: hw/rtl/ps2kd_pkg.sv
`default_nettype none

package ps2kd_pkg;

   localparam logic [7:0] PREFIX_BYTE = 8'hE0;
   localparam logic [7:0] EXT_HIGH    = 8'hE0;

   // Key codes that drive the held-key register.
   localparam logic [6:0] CODE_ALT    = 7'h38;
   localparam logic [6:0] CODE_CTRL   = 7'h1D;
   localparam logic [6:0] CODE_LSUPER = 7'h5B;
   localparam logic [6:0] CODE_RSUPER = 7'h5C;
   localparam logic [6:0] CODE_LSHIFT = 7'h2A;
   localparam logic [6:0] CODE_RSHIFT = 7'h36;

   localparam int HeldWidth = 7;
   localparam int ModWidth  = 5;

   typedef logic [HeldWidth-1:0] held_type;
   typedef logic [ModWidth-1:0]  mods_type;

   localparam held_type HELD_ALT    = 7'h01;
   localparam held_type HELD_CTRL   = 7'h02;
   localparam held_type HELD_LSHIFT = 7'h04;
   localparam held_type HELD_RSHIFT = 7'h08;
   localparam held_type HELD_LSUPER = 7'h10;
   localparam held_type HELD_RSUPER = 7'h20;
   localparam held_type HELD_ALTGR  = 7'h40;

   typedef struct packed {
      logic [15:0] key_code;
      logic [6:0]  key_char;
      mods_type    modifier_set;
   } result_type;

   // US layout: plain and shifted character for one key code, 0 where unmapped.
   function automatic logic [6:0] key_char_lookup(input logic [6:0] code, input logic shift);
      logic [6:0] plain;
      logic [6:0] shifted;
      plain   = 7'h00;
      shifted = 7'h00;
      case (code)
         7'h02: begin plain = 7'h31; shifted = 7'h21; end
         7'h03: begin plain = 7'h32; shifted = 7'h40; end
         7'h04: begin plain = 7'h33; shifted = 7'h23; end
         7'h05: begin plain = 7'h34; shifted = 7'h24; end
         7'h06: begin plain = 7'h35; shifted = 7'h25; end
         7'h07: begin plain = 7'h36; shifted = 7'h5E; end
         7'h08: begin plain = 7'h37; shifted = 7'h26; end
         7'h09: begin plain = 7'h38; shifted = 7'h2A; end
         7'h0A: begin plain = 7'h39; shifted = 7'h28; end
         7'h0B: begin plain = 7'h30; shifted = 7'h29; end
         7'h0C: begin plain = 7'h2D; shifted = 7'h5F; end
         7'h0D: begin plain = 7'h3D; shifted = 7'h2B; end
         7'h0E: begin plain = 7'h08; shifted = 7'h08; end
         7'h0F: begin plain = 7'h09; shifted = 7'h09; end
         7'h10: begin plain = 7'h71; shifted = 7'h51; end
         7'h11: begin plain = 7'h77; shifted = 7'h57; end
         7'h12: begin plain = 7'h65; shifted = 7'h45; end
         7'h13: begin plain = 7'h72; shifted = 7'h52; end
         7'h14: begin plain = 7'h74; shifted = 7'h54; end
         7'h15: begin plain = 7'h79; shifted = 7'h59; end
         7'h16: begin plain = 7'h75; shifted = 7'h55; end
         7'h17: begin plain = 7'h69; shifted = 7'h49; end
         7'h18: begin plain = 7'h6F; shifted = 7'h4F; end
         7'h19: begin plain = 7'h70; shifted = 7'h50; end
         7'h1A: begin plain = 7'h5B; shifted = 7'h7B; end
         7'h1B: begin plain = 7'h5D; shifted = 7'h7D; end
         7'h1C: begin plain = 7'h0A; shifted = 7'h0A; end
         7'h1E: begin plain = 7'h61; shifted = 7'h41; end
         7'h1F: begin plain = 7'h73; shifted = 7'h53; end
         7'h20: begin plain = 7'h64; shifted = 7'h44; end
         7'h21: begin plain = 7'h66; shifted = 7'h46; end
         7'h22: begin plain = 7'h67; shifted = 7'h47; end
         7'h23: begin plain = 7'h68; shifted = 7'h48; end
         7'h24: begin plain = 7'h6A; shifted = 7'h4A; end
         7'h25: begin plain = 7'h6B; shifted = 7'h4B; end
         7'h26: begin plain = 7'h6C; shifted = 7'h4C; end
         7'h27: begin plain = 7'h3B; shifted = 7'h3A; end
         7'h28: begin plain = 7'h27; shifted = 7'h22; end
         7'h29: begin plain = 7'h60; shifted = 7'h7E; end
         7'h2B: begin plain = 7'h5C; shifted = 7'h7C; end
         7'h2C: begin plain = 7'h7A; shifted = 7'h5A; end
         7'h2D: begin plain = 7'h78; shifted = 7'h58; end
         7'h2E: begin plain = 7'h63; shifted = 7'h43; end
         7'h2F: begin plain = 7'h76; shifted = 7'h56; end
         7'h30: begin plain = 7'h62; shifted = 7'h42; end
         7'h31: begin plain = 7'h6E; shifted = 7'h4E; end
         7'h32: begin plain = 7'h6D; shifted = 7'h4D; end
         7'h33: begin plain = 7'h2C; shifted = 7'h3C; end
         7'h34: begin plain = 7'h2E; shifted = 7'h3E; end
         7'h35: begin plain = 7'h2F; shifted = 7'h3F; end
         7'h37: begin plain = 7'h2A; shifted = 7'h2A; end
         7'h39: begin plain = 7'h20; shifted = 7'h20; end
         7'h47: begin plain = 7'h37; shifted = 7'h37; end
         7'h48: begin plain = 7'h38; shifted = 7'h38; end
         7'h49: begin plain = 7'h39; shifted = 7'h39; end
         7'h4A: begin plain = 7'h2D; shifted = 7'h2D; end
         7'h4B: begin plain = 7'h34; shifted = 7'h34; end
         7'h4C: begin plain = 7'h35; shifted = 7'h35; end
         7'h4D: begin plain = 7'h36; shifted = 7'h36; end
         7'h4E: begin plain = 7'h2B; shifted = 7'h2B; end
         7'h4F: begin plain = 7'h31; shifted = 7'h31; end
         7'h50: begin plain = 7'h32; shifted = 7'h32; end
         7'h51: begin plain = 7'h33; shifted = 7'h33; end
         7'h52: begin plain = 7'h30; shifted = 7'h30; end
         7'h53: begin plain = 7'h2E; shifted = 7'h2E; end
         7'h56: begin plain = 7'h5C; shifted = 7'h7C; end
         default: begin plain = 7'h00; shifted = 7'h00; end
      endcase
      return shift ? shifted : plain;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ps2_scancode_key_decoder.sv
// Each scan byte is registered in the input register, and its result is then
// registered in the output register; the prefix byte 0xE0 gives no result.
// Throughput: one scan byte per cycle while the output is not stalled.
// While a result waits, the input register takes one more scan byte and holds it
// until the result is taken; a prefix byte held there never waits.
// Synchronous active-high reset clears the prefix flag, the held keys and valid flags.
`default_nettype none

module ps2_scancode_key_decoder
   import ps2kd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] scan_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [15:0] key_code, [22:16] key_char,
                                         // [27:23] modifier_set, [31:28] zero
   output logic             rsp_tuser    // [0] is_press
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   logic       rsp_press_ff;
   logic       prefix_ff, prefix_in;
   held_type   held_ff, held_in;

   logic       is_prefix;
   logic [6:0] code;
   logic       press;
   held_type   held_mask;
   mods_type   mods;
   result_type result;
   logic       rsp_room;
   logic       rsp_load;
   logic       in_move;

   assign is_prefix = (in_byte_ff == PREFIX_BYTE);
   assign code      = in_byte_ff[6:0];
   assign press     = ~in_byte_ff[7];

   assign rsp_room   = ~rsp_valid_ff | rsp_tready;
   assign in_move    = in_valid_ff & (is_prefix | rsp_room);
   assign rsp_load   = in_valid_ff & ~is_prefix & rsp_room;
   assign req_tready = ~in_valid_ff | in_move;

   always_comb begin
      unique case (code)
         CODE_ALT:    held_mask = prefix_ff ? HELD_ALTGR : HELD_ALT;
         CODE_CTRL:   held_mask = HELD_CTRL;
         CODE_LSUPER: held_mask = HELD_LSUPER;
         CODE_RSUPER: held_mask = HELD_RSUPER;
         CODE_LSHIFT: held_mask = HELD_LSHIFT;
         CODE_RSHIFT: held_mask = HELD_RSHIFT;
         default:     held_mask = '0;
      endcase
   end

   always_comb begin
      held_in   = held_ff;
      prefix_in = prefix_ff;
      if (in_move) begin
         if (is_prefix) begin
            prefix_in = 1'b1;
         end else begin
            held_in   = press ? (held_ff | held_mask) : (held_ff & ~held_mask);
            prefix_in = 1'b0;
         end
      end
   end

   // The modifier set and the shift choice both see this item's update.
   assign mods[0] = |(held_in & HELD_ALT);
   assign mods[1] = |(held_in & HELD_CTRL);
   assign mods[2] = |(held_in & (HELD_LSHIFT | HELD_RSHIFT));
   assign mods[3] = |(held_in & (HELD_LSUPER | HELD_RSUPER));
   assign mods[4] = |(held_in & HELD_ALTGR);

   assign result.key_code     = {(prefix_ff ? EXT_HIGH : 8'h00), 1'b0, code};
   assign result.key_char     = key_char_lookup(code, mods[2]);
   assign result.modifier_set = mods;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (in_move) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prefix_ff    <= 1'b0;
         held_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         prefix_ff    <= prefix_in;
         held_ff      <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (rsp_load) begin
         rsp_data_ff  <= result;
         rsp_press_ff <= press;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, rsp_data_ff.modifier_set, rsp_data_ff.key_char,
                        rsp_data_ff.key_code};
   assign rsp_tuser  = rsp_press_ff;

`ifndef SYNTH
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (held_ff == '0) && !prefix_ff && !rsp_valid_ff)
      else $error("reset did not clear the key state");

   a_prefix_silent: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && is_prefix) |-> !rsp_load)
      else $error("prefix byte produced a result");

   a_prefix_consumed: assert property (@(posedge clock) disable iff (reset)
      (in_move && !is_prefix) |=> !prefix_ff)
      else $error("prefix flag survived a key byte");

   a_extended_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && prefix_ff) |=> (rsp_tdata[15:8] == EXT_HIGH))
      else $error("extended key code lost its prefix");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
module tb;
   import ps2kd_pkg::*;

   localparam int CycleLimit  = 600000;
   localparam int EventTarget = 2000;
   localparam int ShiftBit    = 2;

   typedef struct packed {
      logic [15:0] key_code;
      logic [6:0]  key_char;
      mods_type    modifier_set;
      logic        is_press;
   } key_event_type;

   typedef struct {
      logic [7:0]    scan;
      bit            typed;
      key_event_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   // Predictor state: the prefix flag, the held keys and the two US-layout tables.
   bit          prefix_armed;
   held_type    held_keys;
   logic [6:0]  plain_char[128];
   logic [6:0]  shift_char[128];

   key_event_type pending_events[$];
   stim_row_type  directed_rows[$];
   key_event_type seen_event;
   int            errors;
   int            cycles;
   int            stall_left;
   bit            quiet;

   ps2_scancode_key_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on %s at cycle %0d: got 0x%0h, expected 0x%0h",
               what, cycles, got, want);
      errors++;
   endtask

   function automatic void put_keys(input int base, input string plain, input string shifted);
      for (int i = 0; i < plain.len(); i++) begin
         plain_char[base + i] = 7'(plain[i]);
         shift_char[base + i] = 7'(shifted[i]);
      end
   endfunction

   function automatic void build_key_tables();
      for (int i = 0; i < 128; i++) begin
         plain_char[i] = 7'h00;
         shift_char[i] = 7'h00;
      end
      put_keys('h02, "1234567890-=", "!@#$%^&*()_+");
      put_keys('h10, "qwertyuiop[]", "QWERTYUIOP{}");
      put_keys('h1E, "asdfghjkl;'", "ASDFGHJKL:\"");
      put_keys('h2B, "\\zxcvbnm,./", "|ZXCVBNM<>?");
      put_keys('h47, "789-456+1230.", "789-456+1230.");
      put_keys('h56, "\\", "|");
      put_keys('h37, "*", "*");
      put_keys('h39, " ", " ");
      // Backspace, tab, newline and the back-quote key are not printable in a literal.
      plain_char[8'h0E] = 7'h08;  shift_char[8'h0E] = 7'h08;
      plain_char[8'h0F] = 7'h09;  shift_char[8'h0F] = 7'h09;
      plain_char[8'h1C] = 7'h0A;  shift_char[8'h1C] = 7'h0A;
      plain_char[8'h29] = 7'h60;  shift_char[8'h29] = 7'h7E;
   endfunction

   function automatic key_event_type decode_scan(input logic [7:0] scan, output bit emits);
      key_event_type ev;
      logic [6:0]    code;
      logic          press;
      held_type      touched;
      mods_type      mods;
      ev    = '0;
      emits = 1'b0;
      if (scan == PREFIX_BYTE) begin
         prefix_armed = 1'b1;
         return ev;
      end
      code    = scan[6:0];
      press   = !scan[7];
      touched = '0;
      case (code)
         CODE_ALT:    touched = prefix_armed ? HELD_ALTGR : HELD_ALT;
         CODE_CTRL:   touched = HELD_CTRL;
         CODE_LSUPER: touched = HELD_LSUPER;
         CODE_RSUPER: touched = HELD_RSUPER;
         CODE_LSHIFT: touched = HELD_LSHIFT;
         CODE_RSHIFT: touched = HELD_RSHIFT;
         default:     touched = '0;
      endcase
      if (press) held_keys = held_keys | touched;
      else held_keys = held_keys & ~touched;
      // Left and right keys of a pair fold into a single modifier bit.
      mods = {|(held_keys & HELD_ALTGR),
              |(held_keys & (HELD_LSUPER | HELD_RSUPER)),
              |(held_keys & (HELD_LSHIFT | HELD_RSHIFT)),
              |(held_keys & HELD_CTRL),
              |(held_keys & HELD_ALT)};
      ev.key_code     = prefix_armed ? {EXT_HIGH, 1'b0, code} : {9'h000, code};
      ev.key_char     = mods[ShiftBit] ? shift_char[code] : plain_char[code];
      ev.modifier_set = mods;
      ev.is_press     = press;
      prefix_armed    = 1'b0;
      emits           = 1'b1;
      return ev;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Weighted toward modifier keys and prefix bytes, so the held-key register sees real use.
   function automatic logic [7:0] random_scan();
      int         pick;
      logic [6:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 15) return PREFIX_BYTE;
      if (pick < 45) begin
         case ($urandom_range(0, 5))
            0:       code = CODE_ALT;
            1:       code = CODE_CTRL;
            2:       code = CODE_LSUPER;
            3:       code = CODE_RSUPER;
            4:       code = CODE_LSHIFT;
            default: code = CODE_RSHIFT;
         endcase
         return {1'($urandom_range(0, 1)), code};
      end
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_row(input logic [7:0] scan, input bit typed = 1'b0,
                          input key_event_type want = '0);
      stim_row_type row;
      row.scan  = scan;
      row.typed = typed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic send_scan(input logic [7:0] scan, input bit typed, input key_event_type want);
      int            gap;
      bit            emits;
      key_event_type ev;
      gap = idle_len();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= scan;
      do @(posedge clock); while (!req_tready);
      ev = decode_scan(scan, emits);
      if (emits) pending_events.push_back(typed ? want : ev);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_events.size() == 0) begin
            report_mismatch("item with nothing expected", rsp_tdata, 32'h0);
         end else begin
            seen_event = pending_events.pop_front();
            if (rsp_tdata[15:0] !== seen_event.key_code)
               report_mismatch("key_code", 32'(rsp_tdata[15:0]),
                               32'(seen_event.key_code));
            if (rsp_tdata[22:16] !== seen_event.key_char)
               report_mismatch("key_char", 32'(rsp_tdata[22:16]),
                               32'(seen_event.key_char));
            if (rsp_tdata[27:23] !== seen_event.modifier_set)
               report_mismatch("modifier_set", 32'(rsp_tdata[27:23]),
                               32'(seen_event.modifier_set));
            if (rsp_tdata[31:28] !== 4'h0)
               report_mismatch("tdata padding", 32'(rsp_tdata[31:28]), 32'h0);
            if (rsp_tuser !== seen_event.is_press)
               report_mismatch("is_press", 32'(rsp_tuser), 32'(seen_event.is_press));
         end
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= idle_len();
      end
   end

   initial begin
      int  sent_events;
      bit  drained;
      logic [7:0] scan;
      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      rsp_tready   = 1'b0;
      errors       = 0;
      cycles       = 0;
      stall_left   = 0;
      quiet        = 1'b0;
      prefix_armed = 1'b0;
      held_keys    = '0;
      sent_events  = 0;
      drained      = 1'b0;
      build_key_tables();

      // Rows with a typed result need nothing but the state just after reset.
      add_row(8'h00, 1'b1, '{16'h0000, 7'h00, 5'h00, 1'b1});
      add_row(8'hFF, 1'b1, '{16'h007F, 7'h00, 5'h00, 1'b0});
      add_row(8'h02, 1'b1, '{16'h0002, 7'h31, 5'h00, 1'b1});
      add_row(8'h2A);
      add_row(8'h02);
      add_row(8'h36);
      add_row(8'hAA);
      add_row(8'h10);
      add_row(8'hB6);
      // Two prefixes in a row, then alt, which becomes altgr.
      add_row(PREFIX_BYTE);
      add_row(PREFIX_BYTE);
      add_row(8'h38);
      add_row(8'h38);
      // Prefixed ctrl and super drive the same held bits as the plain ones.
      add_row(PREFIX_BYTE);
      add_row(8'h1D);
      add_row(PREFIX_BYTE);
      add_row(8'h5B);
      add_row(8'h5C);
      add_row(PREFIX_BYTE);
      add_row(8'hB8);
      add_row(8'hB8);
      add_row(8'h9D);
      add_row(8'hDB);
      add_row(8'hDC);
      // Releasing a shift that is not held, then a prefixed unmapped release.
      add_row(8'hAA);
      add_row(PREFIX_BYTE);
      add_row(8'h80);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_scan(directed_rows[i].scan, directed_rows[i].typed, directed_rows[i].want);

      while (sent_events < EventTarget) begin
         if (sent_events % 250 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (!drained && sent_events >= EventTarget / 2) begin
            // Hold the sender back until every outstanding item has come out.
            drained = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_events.size() != 0) @(posedge clock);
         end
         scan = random_scan();
         send_scan(scan, 1'b0, '0);
         sent_events++;
      end
      req_tvalid <= 1'b0;

      while (pending_events.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: ps2_scancode_key_decoder.f
hw/rtl/ps2kd_pkg.sv
hw/rtl/ps2_scancode_key_decoder.sv
test/tb.sv
